// ----- design/slx_pkg.sv -----
// Shared types, character codes and decode helpers for the s-expression lexer.
package slx_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int MAX_RES     = 4;

  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_APOS   = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_NL     = 8'h0A;

  typedef enum logic [6:0] {
    MODE_IDLE    = 7'b0000001,
    MODE_COMMENT = 7'b0000010,
    MODE_STRING  = 7'b0000100,
    MODE_NUMBER  = 7'b0001000,
    MODE_ATOM    = 7'b0010000,
    MODE_MINUS   = 7'b0100000,
    MODE_ERROR   = 7'b1000000
  } mode_t;

  typedef enum logic [2:0] {
    KIND_LPAREN = 3'd0,
    KIND_RPAREN = 3'd1,
    KIND_QUOTE  = 3'd2,
    KIND_STRING = 3'd3,
    KIND_NUMBER = 3'd4,
    KIND_ATOM   = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_DOT     = 2'd1,
    ERR_UNTERM  = 2'd2
  } err_t;

  // One result as it leaves the block (last_result is added at the back).
  typedef struct packed {
    kind_t      token_kind;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       token_start;
    logic       token_end;
    err_t       error_code;
  } res_t;

  // All results caused by one input byte.
  typedef struct packed {
    logic [2:0]         count;
    res_t [MAX_RES-1:0] res;
  } bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic is_space(logic [7:0] c);
    return (c == 8'h20) || (c inside {[8'h09:8'h0D]});
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_delim(logic [7:0] c);
    return is_space(c) ||
           (c inside {CH_LPAREN, CH_RPAREN, CH_DQUOTE, CH_APOS, CH_SEMI, CH_COMMA});
  endfunction

  function automatic res_t mk_res(kind_t k, logic [7:0] b, logic has, logic st,
                                  logic en, err_t e);
    res_t r;
    r.token_kind  = k;
    r.data_byte   = has ? b : 8'h00;
    r.has_byte    = has;
    r.token_start = st;
    r.token_end   = en;
    r.error_code  = e;
    return r;
  endfunction

endpackage

// ----- design/slx_ifs.sv -----
// Valid/ready channel interfaces for the source bytes and the token results.
interface slx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       end_of_input;

  modport source (output valid, char_byte, end_of_input, input ready);
  modport sink   (input valid, char_byte, end_of_input, output ready);
endinterface

interface slx_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] token_kind;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       token_start;
  logic       token_end;
  logic [1:0] error_code;
  logic       last_result;

  modport source (output valid, token_kind, data_byte, has_byte, token_start, token_end,
                  error_code, last_result, input ready);
  modport sink   (input valid, token_kind, data_byte, has_byte, token_start, token_end,
                  error_code, last_result, output ready);
endinterface

// ----- design/slx_front.sv -----
// Front end: classify each source byte, advance the lexer mode, build its result bundle.
module slx_front (
  input  logic                clk,
  input  logic                rst_n,
  slx_in_if.sink              in_chan,
  input  slx_pkg::q_status_t  q_stat,
  output logic                push,
  output slx_pkg::bundle_t    push_bundle
);

  slx_pkg::mode_t   mode_r, mode_nxt;
  logic             dot_r, dot_nxt;
  logic             in_fire;
  logic [7:0]       c;
  logic             eoi;

  // what a byte does when lexed from idle
  slx_pkg::res_t    idle_res;
  logic             idle_emit;
  slx_pkg::mode_t   idle_mode;
  logic             idle_clr;

  slx_pkg::bundle_t bnd;
  logic [2:0]       n;

  assign c       = in_chan.char_byte;
  assign eoi     = in_chan.end_of_input;
  assign in_chan.ready = !q_stat.full;
  assign in_fire = in_chan.valid && in_chan.ready;

  always_comb begin
    idle_emit = 1'b0;
    idle_clr  = 1'b0;
    idle_mode = slx_pkg::MODE_IDLE;
    idle_res  = slx_pkg::mk_res(slx_pkg::KIND_ATOM, c, 1'b1, 1'b1, 1'b0, slx_pkg::ERR_NONE);
    if (slx_pkg::is_space(c) || c == slx_pkg::CH_COMMA) begin
      idle_mode = slx_pkg::MODE_IDLE;
    end else if (c == slx_pkg::CH_SEMI) begin
      idle_mode = slx_pkg::MODE_COMMENT;
    end else if (c == slx_pkg::CH_LPAREN) begin
      idle_emit = 1'b1;
      idle_res  = slx_pkg::mk_res(slx_pkg::KIND_LPAREN, c, 1'b1, 1'b1, 1'b1,
                                  slx_pkg::ERR_NONE);
    end else if (c == slx_pkg::CH_RPAREN) begin
      idle_emit = 1'b1;
      idle_res  = slx_pkg::mk_res(slx_pkg::KIND_RPAREN, c, 1'b1, 1'b1, 1'b1,
                                  slx_pkg::ERR_NONE);
    end else if (c == slx_pkg::CH_APOS) begin
      idle_emit = 1'b1;
      idle_res  = slx_pkg::mk_res(slx_pkg::KIND_QUOTE, c, 1'b1, 1'b1, 1'b1,
                                  slx_pkg::ERR_NONE);
    end else if (c == slx_pkg::CH_DQUOTE) begin
      idle_emit = 1'b1;
      idle_mode = slx_pkg::MODE_STRING;
      idle_res  = slx_pkg::mk_res(slx_pkg::KIND_STRING, c, 1'b0, 1'b1, 1'b0,
                                  slx_pkg::ERR_NONE);
    end else if (slx_pkg::is_digit(c)) begin
      idle_emit = 1'b1;
      idle_clr  = 1'b1;
      idle_mode = slx_pkg::MODE_NUMBER;
      idle_res  = slx_pkg::mk_res(slx_pkg::KIND_NUMBER, c, 1'b1, 1'b1, 1'b0,
                                  slx_pkg::ERR_NONE);
    end else if (c == slx_pkg::CH_MINUS) begin
      idle_mode = slx_pkg::MODE_MINUS;
    end else begin
      idle_emit = 1'b1;
      idle_mode = slx_pkg::MODE_ATOM;
    end
  end

  always_comb begin
    mode_nxt = mode_r;
    dot_nxt  = dot_r;
    n        = 3'd0;
    bnd      = '0;

    case (mode_r)
      slx_pkg::MODE_ERROR: begin
        mode_nxt = slx_pkg::MODE_ERROR;
      end
      slx_pkg::MODE_COMMENT: begin
        if (c == slx_pkg::CH_NL) mode_nxt = slx_pkg::MODE_IDLE;
      end
      slx_pkg::MODE_STRING: begin
        if (c == slx_pkg::CH_DQUOTE) begin
          bnd.res[n[1:0]] = slx_pkg::mk_res(slx_pkg::KIND_STRING, c, 1'b0, 1'b0, 1'b1,
                                            slx_pkg::ERR_NONE);
          n = n + 3'd1;
          mode_nxt = slx_pkg::MODE_IDLE;
        end else begin
          bnd.res[n[1:0]] = slx_pkg::mk_res(slx_pkg::KIND_STRING, c, 1'b1, 1'b0, 1'b0,
                                            slx_pkg::ERR_NONE);
          n = n + 3'd1;
        end
      end
      slx_pkg::MODE_NUMBER: begin
        if (slx_pkg::is_digit(c)) begin
          bnd.res[n[1:0]] = slx_pkg::mk_res(slx_pkg::KIND_NUMBER, c, 1'b1, 1'b0, 1'b0,
                                            slx_pkg::ERR_NONE);
          n = n + 3'd1;
        end else if (c == slx_pkg::CH_DOT) begin
          if (dot_r) begin
            bnd.res[n[1:0]] = slx_pkg::mk_res(slx_pkg::KIND_NUMBER, c, 1'b0, 1'b0, 1'b1,
                                              slx_pkg::ERR_DOT);
            n = n + 3'd1;
            mode_nxt = slx_pkg::MODE_ERROR;
          end else begin
            dot_nxt = 1'b1;
            bnd.res[n[1:0]] = slx_pkg::mk_res(slx_pkg::KIND_NUMBER, c, 1'b1, 1'b0, 1'b0,
                                              slx_pkg::ERR_NONE);
            n = n + 3'd1;
          end
        end else begin
          // close the number, then lex the byte again from idle
          bnd.res[n[1:0]] = slx_pkg::mk_res(slx_pkg::KIND_NUMBER, c, 1'b0, 1'b0, 1'b1,
                                            slx_pkg::ERR_NONE);
          n = n + 3'd1;
          dot_nxt = 1'b0;
          if (idle_emit) begin
            bnd.res[n[1:0]] = idle_res;
            n = n + 3'd1;
          end
          mode_nxt = idle_mode;
        end
      end
      slx_pkg::MODE_ATOM: begin
        if (slx_pkg::is_delim(c)) begin
          bnd.res[n[1:0]] = slx_pkg::mk_res(slx_pkg::KIND_ATOM, c, 1'b0, 1'b0, 1'b1,
                                            slx_pkg::ERR_NONE);
          n = n + 3'd1;
          if (idle_emit) begin
            bnd.res[n[1:0]] = idle_res;
            n = n + 3'd1;
          end
          if (idle_clr) dot_nxt = 1'b0;
          mode_nxt = idle_mode;
        end else begin
          bnd.res[n[1:0]] = slx_pkg::mk_res(slx_pkg::KIND_ATOM, c, 1'b1, 1'b0, 1'b0,
                                            slx_pkg::ERR_NONE);
          n = n + 3'd1;
        end
      end
      slx_pkg::MODE_MINUS: begin
        if (slx_pkg::is_digit(c)) begin
          bnd.res[n[1:0]] = slx_pkg::mk_res(slx_pkg::KIND_NUMBER, slx_pkg::CH_MINUS, 1'b1,
                                            1'b1, 1'b0, slx_pkg::ERR_NONE);
          n = n + 3'd1;
          bnd.res[n[1:0]] = slx_pkg::mk_res(slx_pkg::KIND_NUMBER, c, 1'b1, 1'b0, 1'b0,
                                            slx_pkg::ERR_NONE);
          n = n + 3'd1;
          dot_nxt  = 1'b0;
          mode_nxt = slx_pkg::MODE_NUMBER;
        end else begin
          // the held minus opens an atom, this byte continues or ends it
          bnd.res[n[1:0]] = slx_pkg::mk_res(slx_pkg::KIND_ATOM, slx_pkg::CH_MINUS, 1'b1,
                                            1'b1, 1'b0, slx_pkg::ERR_NONE);
          n = n + 3'd1;
          mode_nxt = slx_pkg::MODE_ATOM;
          if (slx_pkg::is_delim(c)) begin
            bnd.res[n[1:0]] = slx_pkg::mk_res(slx_pkg::KIND_ATOM, c, 1'b0, 1'b0, 1'b1,
                                              slx_pkg::ERR_NONE);
            n = n + 3'd1;
            if (idle_emit) begin
              bnd.res[n[1:0]] = idle_res;
              n = n + 3'd1;
            end
            if (idle_clr) dot_nxt = 1'b0;
            mode_nxt = idle_mode;
          end else begin
            bnd.res[n[1:0]] = slx_pkg::mk_res(slx_pkg::KIND_ATOM, c, 1'b1, 1'b0, 1'b0,
                                              slx_pkg::ERR_NONE);
            n = n + 3'd1;
          end
        end
      end
      default: begin
        if (idle_emit) begin
          bnd.res[n[1:0]] = idle_res;
          n = n + 3'd1;
        end
        if (idle_clr) dot_nxt = 1'b0;
        mode_nxt = idle_mode;
      end
    endcase

    // end of input closes whatever token is still open
    if (eoi) begin
      case (mode_nxt)
        slx_pkg::MODE_NUMBER: begin
          bnd.res[n[1:0]] = slx_pkg::mk_res(slx_pkg::KIND_NUMBER, c, 1'b0, 1'b0, 1'b1,
                                            slx_pkg::ERR_NONE);
          n = n + 3'd1;
        end
        slx_pkg::MODE_ATOM: begin
          bnd.res[n[1:0]] = slx_pkg::mk_res(slx_pkg::KIND_ATOM, c, 1'b0, 1'b0, 1'b1,
                                            slx_pkg::ERR_NONE);
          n = n + 3'd1;
        end
        slx_pkg::MODE_MINUS: begin
          bnd.res[n[1:0]] = slx_pkg::mk_res(slx_pkg::KIND_ATOM, slx_pkg::CH_MINUS, 1'b1,
                                            1'b1, 1'b0, slx_pkg::ERR_NONE);
          n = n + 3'd1;
          bnd.res[n[1:0]] = slx_pkg::mk_res(slx_pkg::KIND_ATOM, c, 1'b0, 1'b0, 1'b1,
                                            slx_pkg::ERR_NONE);
          n = n + 3'd1;
        end
        slx_pkg::MODE_STRING: begin
          bnd.res[n[1:0]] = slx_pkg::mk_res(slx_pkg::KIND_STRING, c, 1'b0, 1'b0, 1'b1,
                                            slx_pkg::ERR_UNTERM);
          n = n + 3'd1;
        end
        default: begin
        end
      endcase
      mode_nxt = slx_pkg::MODE_IDLE;
      dot_nxt  = 1'b0;
    end

    bnd.count = n;
  end

  assign push        = in_fire && (n != 3'd0);
  assign push_bundle = bnd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= slx_pkg::MODE_IDLE;
      dot_r  <= 1'b0;
    end else if (in_fire) begin
      mode_r <= mode_nxt;
      dot_r  <= dot_nxt;
    end
  end

endmodule

// ----- design/slx_queue.sv -----
// Short bundle queue between the front end and the result sequencer.
module slx_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  slx_pkg::bundle_t    push_bundle,
  input  logic                pop,
  output slx_pkg::bundle_t    head_bundle,
  output slx_pkg::q_status_t  q_stat
);

  slx_pkg::bundle_t               mem_r [slx_pkg::QUEUE_DEPTH];
  logic [slx_pkg::QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [slx_pkg::QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [slx_pkg::QPTR_W:0]       count_r, count_nxt;

  assign q_stat.full  = (count_r == (slx_pkg::QPTR_W+1)'(slx_pkg::QUEUE_DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign head_bundle  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (slx_pkg::QPTR_W+1)'(push) - (slx_pkg::QPTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_bundle;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ----- design/slx_back.sv -----
// Back end: head bundle to output register, one result per cycle if not stalled.
module slx_back (
  input  logic                clk,
  input  logic                rst_n,
  input  slx_pkg::bundle_t    head_bundle,
  input  slx_pkg::q_status_t  q_stat,
  output logic                pop,
  slx_out_if.source           out_chan
);

  logic [1:0]     idx_r, idx_nxt;
  logic           out_valid_r, out_valid_nxt;
  slx_pkg::res_t  out_res_r;
  logic           out_last_r;
  logic           load;
  logic           is_last;

  assign load    = !q_stat.empty && (!out_valid_r || out_chan.ready);
  assign is_last = ({1'b0, idx_r} == head_bundle.count - 3'd1);
  assign pop     = load && is_last;

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    if (load) begin
      out_valid_nxt = 1'b1;
      idx_nxt       = is_last ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res_r  <= head_bundle.res[idx_r];
      out_last_r <= is_last;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.token_kind  = out_res_r.token_kind;
  assign out_chan.data_byte   = out_res_r.data_byte;
  assign out_chan.has_byte    = out_res_r.has_byte;
  assign out_chan.token_start = out_res_r.token_start;
  assign out_chan.token_end   = out_res_r.token_end;
  assign out_chan.error_code  = out_res_r.error_code;
  assign out_chan.last_result = out_last_r;

endmodule

// ----- design/s_expression_lexer_unit.sv -----
// Path: request bundle into the queue, first result into the output register (two stages).
// Throughput: one source byte per cycle while no byte yields more than one result and the
//   receiver does not stall; the single output register passes a byte's results one by one.
// A four-entry bundle queue absorbs such bursts so the front keeps taking bytes meanwhile.
// Reset (rst_n low, synchronous): lexer idle, dot flag clear, queue empty, no output valid.
module s_expression_lexer_unit (
  input  logic       clk,
  input  logic       rst_n,
  slx_in_if.sink     in_chan,
  slx_out_if.source  out_chan
);

  // Front end: decode the byte class and step the lexer mode in the same cycle the
  // request is taken; every result the byte causes is packed into one bundle.
  logic               q_push;
  slx_pkg::bundle_t   push_bundle;
  slx_pkg::bundle_t   head_bundle;
  slx_pkg::q_status_t q_stat;
  logic               q_pop;

  slx_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .q_stat      (q_stat),
    .push        (q_push),
    .push_bundle (push_bundle)
  );

  // Queue: hold bundles so the front stalls only when all entries are taken.
  slx_queue u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (q_push),
    .push_bundle (push_bundle),
    .pop         (q_pop),
    .head_bundle (head_bundle),
    .q_stat      (q_stat)
  );

  // Back end: advance through the head bundle, drop it after its last result.
  slx_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head_bundle (head_bundle),
    .q_stat      (q_stat),
    .pop         (q_pop),
    .out_chan    (out_chan)
  );

  // A bundle is never written into a full queue.
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("bundle pushed into full queue");

  // Every pushed bundle carries between one and four results.
  a_bundle_count: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (push_bundle.count != 3'd0) && (push_bundle.count <= 3'd4))
    else $error("bundle result count out of range");

  // Nothing can appear at the output without a queued bundle behind it.
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    (q_stat.empty && !out_chan.valid) |=> !out_chan.valid)
    else $error("result emitted from empty queue");

  // Error results only close a token and carry no text.
  a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.error_code != slx_pkg::ERR_NONE) |->
      (out_chan.token_end && !out_chan.has_byte && !out_chan.token_start))
    else $error("malformed error result");

endmodule

// ----- test/s_expression_lexer_unit_test.sv -----
// Self-checking test of the s-expression lexer: random byte streams, token scoreboard.
module s_expression_lexer_unit_test;
  import slx_pkg::*;

  // One expected result, in the order the block should deliver it.
  typedef struct {
    kind_t      kind;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       tok_start;
    logic       tok_end;
    err_t       err;
    logic       last;
  } token_result_t;

  // One source byte as it is offered to the block.
  typedef struct {
    logic [7:0] char_value;
    logic       last_of_text;
  } source_byte_t;

  // Token scoreboard: tracks the lexer state, predicts the token results of each
  // accepted request and checks the results that come out of the block.
  class token_scoreboard;
    token_result_t expected_tokens[$];
    mode_t         lex_mode;
    bit            dot_seen;
    int            mismatches;
    int            bytes_taken;
    int            results_seen;

    function new();
      lex_mode     = MODE_IDLE;
      dot_seen     = 1'b0;
      mismatches   = 0;
      bytes_taken  = 0;
      results_seen = 0;
    endfunction

    static function bit blank(logic [7:0] c);
      return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    static function bit numeral(logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
    endfunction

    static function bit breaks_token(logic [7:0] c);
      return blank(c) || c == CH_LPAREN || c == CH_RPAREN || c == CH_DQUOTE ||
             c == CH_APOS || c == CH_SEMI || c == CH_COMMA;
    endfunction

    function void push(kind_t k, logic [7:0] b, bit has, bit st, bit en, err_t e);
      token_result_t r;
      r.kind      = k;
      r.data_byte = has ? b : 8'h00;
      r.has_byte  = has;
      r.tok_start = st;
      r.tok_end   = en;
      r.err       = e;
      r.last      = 1'b0;
      expected_tokens.insert(expected_tokens.size(), r);
    endfunction

    function void lex_from_idle(logic [7:0] c);
      if (blank(c) || c == CH_COMMA) begin
        lex_mode = MODE_IDLE;
      end else if (c == CH_SEMI) begin
        lex_mode = MODE_COMMENT;
      end else if (c == CH_LPAREN) begin
        push(KIND_LPAREN, c, 1, 1, 1, ERR_NONE);
        lex_mode = MODE_IDLE;
      end else if (c == CH_RPAREN) begin
        push(KIND_RPAREN, c, 1, 1, 1, ERR_NONE);
        lex_mode = MODE_IDLE;
      end else if (c == CH_APOS) begin
        push(KIND_QUOTE, c, 1, 1, 1, ERR_NONE);
        lex_mode = MODE_IDLE;
      end else if (c == CH_DQUOTE) begin
        push(KIND_STRING, 8'h00, 0, 1, 0, ERR_NONE);
        lex_mode = MODE_STRING;
      end else if (numeral(c)) begin
        push(KIND_NUMBER, c, 1, 1, 0, ERR_NONE);
        dot_seen = 1'b0;
        lex_mode = MODE_NUMBER;
      end else if (c == CH_MINUS) begin
        lex_mode = MODE_MINUS;
      end else begin
        push(KIND_ATOM, c, 1, 1, 0, ERR_NONE);
        lex_mode = MODE_ATOM;
      end
    endfunction

    function void lex_atom_byte(logic [7:0] c);
      if (breaks_token(c)) begin
        push(KIND_ATOM, 8'h00, 0, 0, 1, ERR_NONE);
        lex_mode = MODE_IDLE;
        lex_from_idle(c);
      end else begin
        push(KIND_ATOM, c, 1, 0, 0, ERR_NONE);
      end
    endfunction

    // Predict the results of one accepted request and queue them.
    function void note_source_byte(logic [7:0] c, logic eoi);
      int first;
      first = expected_tokens.size();
      bytes_taken++;
      case (lex_mode)
        MODE_ERROR: ;
        MODE_COMMENT: begin
          if (c == CH_NL) lex_mode = MODE_IDLE;
        end
        MODE_STRING: begin
          if (c == CH_DQUOTE) begin
            push(KIND_STRING, 8'h00, 0, 0, 1, ERR_NONE);
            lex_mode = MODE_IDLE;
          end else begin
            push(KIND_STRING, c, 1, 0, 0, ERR_NONE);
          end
        end
        MODE_NUMBER: begin
          if (numeral(c)) begin
            push(KIND_NUMBER, c, 1, 0, 0, ERR_NONE);
          end else if (c == CH_DOT) begin
            if (dot_seen) begin
              push(KIND_NUMBER, 8'h00, 0, 0, 1, ERR_DOT);
              lex_mode = MODE_ERROR;
            end else begin
              dot_seen = 1'b1;
              push(KIND_NUMBER, c, 1, 0, 0, ERR_NONE);
            end
          end else begin
            push(KIND_NUMBER, 8'h00, 0, 0, 1, ERR_NONE);
            dot_seen = 1'b0;
            lex_mode = MODE_IDLE;
            lex_from_idle(c);
          end
        end
        MODE_ATOM: lex_atom_byte(c);
        MODE_MINUS: begin
          if (numeral(c)) begin
            push(KIND_NUMBER, CH_MINUS, 1, 1, 0, ERR_NONE);
            push(KIND_NUMBER, c, 1, 0, 0, ERR_NONE);
            dot_seen = 1'b0;
            lex_mode = MODE_NUMBER;
          end else begin
            push(KIND_ATOM, CH_MINUS, 1, 1, 0, ERR_NONE);
            lex_mode = MODE_ATOM;
            lex_atom_byte(c);
          end
        end
        default: lex_from_idle(c);
      endcase

      if (eoi) begin
        if (lex_mode == MODE_NUMBER) begin
          push(KIND_NUMBER, 8'h00, 0, 0, 1, ERR_NONE);
        end else if (lex_mode == MODE_ATOM) begin
          push(KIND_ATOM, 8'h00, 0, 0, 1, ERR_NONE);
        end else if (lex_mode == MODE_MINUS) begin
          push(KIND_ATOM, CH_MINUS, 1, 1, 0, ERR_NONE);
          push(KIND_ATOM, 8'h00, 0, 0, 1, ERR_NONE);
        end else if (lex_mode == MODE_STRING) begin
          push(KIND_STRING, 8'h00, 0, 0, 1, ERR_UNTERM);
        end
        lex_mode = MODE_IDLE;
        dot_seen = 1'b0;
      end

      if (expected_tokens.size() > first)
        expected_tokens[expected_tokens.size() - 1].last = 1'b1;
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= 40)
        $display("[%0t] result %0d: %s", $time, results_seen, msg);
    endtask

    task compare_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want)
        report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    // Check one accepted result against the oldest expectation.
    task check_result(logic [2:0] kind, logic [7:0] data, logic has, logic st,
                      logic en, logic [1:0] err, logic last);
      token_result_t want;
      results_seen++;
      if (expected_tokens.size() == 0) begin
        report_mismatch("result arrived with nothing expected");
        return;
      end
      want = expected_tokens.pop_front();
      compare_field("token_kind", 8'(kind), 8'(want.kind));
      compare_field("data_byte", data, want.data_byte);
      compare_field("has_byte", 8'(has), 8'(want.has_byte));
      compare_field("token_start", 8'(st), 8'(want.tok_start));
      compare_field("token_end", 8'(en), 8'(want.tok_end));
      compare_field("error_code", 8'(err), 8'(want.err));
      compare_field("last_result", 8'(last), 8'(want.last));
    endtask
  endclass

  logic clk;
  logic rst_n;

  slx_in_if  src_chan ();
  slx_out_if tok_chan ();

  token_scoreboard sb = new();
  source_byte_t    src_q[$];

  s_expression_lexer_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (src_chan),
    .out_chan (tok_chan)
  );

  // Directed opening: every one-byte token, skipped bytes, a comment, a string
  // with a high byte, a negative number closed by a paren, a second dot with
  // an ignored byte up to end of input, a minus before a quote at end of input
  // (four results from one byte), an atom of a high byte and a minus, an
  // unterminated string with content, and a lone minus at end of input.
  localparam int DIRECTED_COUNT = 26;
  localparam logic [7:0] DIRECTED_BYTES [DIRECTED_COUNT] = '{
    CH_LPAREN, CH_RPAREN, CH_APOS, 8'h09, CH_COMMA, CH_SEMI, CH_NL,
    CH_DQUOTE, 8'hFF, CH_DQUOTE,
    CH_MINUS, 8'h39, CH_DOT, 8'h30, CH_RPAREN,
    8'h31, CH_DOT, CH_DOT, 8'h0D,
    CH_MINUS, CH_DQUOTE,
    8'h80, CH_MINUS,
    CH_DQUOTE, 8'h7F,
    CH_MINUS
  };
  localparam bit DIRECTED_EOI [DIRECTED_COUNT] = '{
    0, 0, 0, 0, 0, 0, 0,
    0, 0, 0,
    0, 0, 0, 0, 0,
    0, 0, 0, 1,
    0, 1,
    0, 1,
    0, 1,
    1
  };
  localparam int RANDOM_COUNT = 440;

  // Free-running clock, period 10.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Append one byte to the source stream.
  function automatic void add_byte(logic [7:0] c);
    source_byte_t b;
    b.char_value   = c;
    b.last_of_text = 1'b0;
    src_q.insert(src_q.size(), b);
  endfunction

  // Pick an atom character; mostly printable, sometimes any non-delimiter byte.
  function automatic logic [7:0] atom_char(bit first);
    logic [7:0] c;
    do begin
      if ($urandom_range(0, 3) != 0) c = 8'($urandom_range(33, 126));
      else c = 8'($urandom_range(0, 255));
    end while (token_scoreboard::breaks_token(c) ||
               (first && (token_scoreboard::numeral(c) || c == CH_MINUS)));
    return c;
  endfunction

  // Pick any byte except the one that would end the current construct.
  function automatic logic [7:0] char_except(logic [7:0] stop);
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == stop);
    return c;
  endfunction

  function automatic logic [7:0] digit_char();
    return 8'h30 + 8'($urandom_range(0, 9));
  endfunction

  // Whitespace or comma between tokens.
  function automatic logic [7:0] spacer_char();
    int k;
    k = $urandom_range(0, 7);
    if (k < 5) return 8'h09 + 8'(k);
    else if (k < 7) return 8'h20;
    else return CH_COMMA;
  endfunction

  // Append one well-formed token, or now and then a noise byte.
  function automatic void add_token();
    int pick;
    int len;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      add_byte($urandom_range(0, 1) ? CH_LPAREN : CH_RPAREN);
    end else if (pick < 20) begin
      add_byte(CH_APOS);
    end else if (pick < 40) begin
      if ($urandom_range(0, 2) == 0) add_byte(CH_MINUS);
      len = $urandom_range(1, 4);
      repeat (len) add_byte(digit_char());
      if ($urandom_range(0, 1)) begin
        add_byte(CH_DOT);
        len = $urandom_range(0, 3);
        repeat (len) add_byte(digit_char());
        // a rare second dot sends the block into error until end of text
        if ($urandom_range(0, 7) == 0) add_byte(CH_DOT);
      end
    end else if (pick < 60) begin
      add_byte(atom_char(1));
      len = $urandom_range(0, 4);
      repeat (len) add_byte(atom_char(0));
    end else if (pick < 75) begin
      add_byte(CH_DQUOTE);
      len = $urandom_range(0, 5);
      repeat (len) add_byte(char_except(CH_DQUOTE));
      add_byte(CH_DQUOTE);
    end else if (pick < 83) begin
      add_byte(CH_SEMI);
      len = $urandom_range(0, 4);
      repeat (len) add_byte(char_except(CH_NL));
      add_byte(CH_NL);
    end else if (pick < 90) begin
      add_byte(CH_MINUS);
    end else begin
      add_byte(8'($urandom_range(0, 255)));
    end
  endfunction

  // Append one source text: a run of tokens, sometimes left open at the end,
  // with end of input on its last byte.
  function automatic void add_text();
    int tokens;
    int len;
    tokens = $urandom_range(1, 10);
    repeat (tokens) begin
      add_token();
      if ($urandom_range(0, 9) < 7) add_byte(spacer_char());
    end
    if ($urandom_range(0, 4) == 0) begin
      case ($urandom_range(0, 2))
        0: begin
          add_byte(CH_DQUOTE);
          len = $urandom_range(0, 3);
          repeat (len) add_byte(char_except(CH_DQUOTE));
        end
        1: add_byte(CH_MINUS);
        default: add_byte(atom_char(1));
      endcase
    end
    src_q[src_q.size() - 1].last_of_text = 1'b1;
  endfunction

  // Offer the whole stream in bursts of random length with random gaps.
  // Valid gets one assignment per clock step, so back-to-back requests keep it high.
  task automatic drive_requests();
    int burst_left;
    int gap;
    burst_left = 0;
    foreach (src_q[i]) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 30);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          src_chan.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
      src_chan.valid        <= 1'b1;
      src_chan.char_byte    <= src_q[i].char_value;
      src_chan.end_of_input <= src_q[i].last_of_text;
      // hold the request until the block takes it
      @(posedge clk);
      while (!src_chan.ready) @(posedge clk);
      sb.note_source_byte(src_q[i].char_value, src_q[i].last_of_text);
    end
    src_chan.valid <= 1'b0;
  endtask

  // Main sequence: reset, build the stream, drive it, drain, judge.
  initial begin
    rst_n                 <= 1'b0;
    src_chan.valid        <= 1'b0;
    src_chan.char_byte    <= 8'h00;
    src_chan.end_of_input <= 1'b0;

    for (int i = 0; i < DIRECTED_COUNT; i++) begin
      add_byte(DIRECTED_BYTES[i]);
      src_q[i].last_of_text = DIRECTED_EOI[i];
    end
    while (src_q.size() < DIRECTED_COUNT + RANDOM_COUNT) add_text();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    drive_requests();

    // drain: wait for every expected result, then give stray results time to show
    while (sb.expected_tokens.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Receiver: stall on a pattern that changes at random intervals, including
  // stretches of no stall at all. Once, after enough requests, hold off for a
  // long stretch so the result queue fills and the block pushes back on input.
  initial begin : result_receiver
    int pattern;
    int pattern_left;
    int hold_left;
    bit long_hold_done;
    pattern        = 0;
    pattern_left   = 0;
    hold_left      = 0;
    long_hold_done = 1'b0;
    tok_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!long_hold_done && sb.bytes_taken >= 150) begin
        long_hold_done = 1'b1;
        hold_left      = 100;
      end
      if (hold_left > 0) begin
        hold_left--;
        tok_chan.ready <= 1'b0;
      end else begin
        if (pattern_left == 0) begin
          pattern      = $urandom_range(0, 3);
          pattern_left = $urandom_range(20, 80);
        end
        pattern_left--;
        case (pattern)
          0: tok_chan.ready <= 1'b1;
          1: tok_chan.ready <= 1'($urandom_range(0, 1));
          2: tok_chan.ready <= ($urandom_range(0, 3) != 0);
          default: tok_chan.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Check every result the block hands over.
  always @(posedge clk) begin
    if (rst_n && tok_chan.valid && tok_chan.ready)
      sb.check_result(tok_chan.token_kind, tok_chan.data_byte, tok_chan.has_byte,
                      tok_chan.token_start, tok_chan.token_end, tok_chan.error_code,
                      tok_chan.last_result);
  end

  // Watchdog: a hang or a lost result ends the run here.
  initial begin : watchdog
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
